/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent assertion helpers for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// shared constants, types and helpers of the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH       = 32;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int PRIO_W      = 16;
  localparam int TYPE_W      = 8;
  localparam int KIND_W      = 4;
  localparam int SPACING_W   = 11;
  localparam int SPACING_RST = 10;
  localparam int BOTTOM_STEP = 10;
  localparam int SUM_W       = ((PRIO_W > SPACING_W + 1) ? PRIO_W : SPACING_W + 1) + 1;

  localparam logic signed [SUM_W-1:0] SUM_PMAX =
    SUM_W'((longint'(1) <<< (PRIO_W - 1)) - longint'(1));
  localparam logic signed [SUM_W-1:0] SUM_PMIN = -SUM_PMAX - SUM_W'(1);

  typedef logic signed [PRIO_W-1:0] prio_t;

  typedef struct packed {
    prio_t             prio;
    logic              blk;
    logic [TYPE_W-1:0] tag;
  } entry_t;

  typedef enum logic [KIND_W-1:0] {
    K_INSERT   = 4'd0,
    K_INS_TOP  = 4'd1,
    K_INS_BOT  = 4'd2,
    K_REM_TOP  = 4'd3,
    K_REM_BOT  = 4'd4,
    K_SKIP     = 4'd5,
    K_GET_TOP  = 4'd6,
    K_GET_CUR  = 4'd7,
    K_COUNT    = 4'd8,
    K_CLEAR    = 4'd9
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_NOSKIP = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_RD,
    S_RD_GET,
    S_RM_RD,
    S_RM_WR,
    S_REF_LO,
    S_REF_HI,
    S_REF_END,
    S_SKIP,
    S_CNT_RD,
    S_CNT_CMP,
    S_FIN_RD,
    S_FIN
  } state_e;

  // clamp a widened sum back into the signed priority range
  function automatic prio_t sat_prio(input logic signed [SUM_W-1:0] v);
    prio_t r;
    if (v > SUM_PMAX) begin
      r = PRIO_W'(SUM_PMAX);
    end else if (v < SUM_PMIN) begin
      r = PRIO_W'(SUM_PMIN);
    end else begin
      r = PRIO_W'(v);
    end
    return r;
  endfunction

endpackage

/* rtl/spq_req_if.sv */
// ----------------------------------------------------------------------------
// spq_req_if
// request channel of the sorted priority queue
// ----------------------------------------------------------------------------
interface spq_req_if;
  logic                             valid;
  logic                             ready;
  logic [spq_pkg::KIND_W-1:0]       kind;
  logic signed [spq_pkg::PRIO_W-1:0] new_priority;
  logic                             new_blocking;
  logic [spq_pkg::TYPE_W-1:0]       type_tag;

  modport source (output valid, kind, new_priority, new_blocking, type_tag, input ready);
  modport sink   (input valid, kind, new_priority, new_blocking, type_tag, output ready);
endinterface

/* rtl/spq_rsp_if.sv */
// ----------------------------------------------------------------------------
// spq_rsp_if
// response channel of the sorted priority queue
// ----------------------------------------------------------------------------
interface spq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic signed [spq_pkg::PRIO_W-1:0] entry_priority;
  logic                              entry_blocking;
  logic [spq_pkg::TYPE_W-1:0]        entry_type;
  logic [spq_pkg::CNT_W-1:0]         type_count;
  logic [spq_pkg::CNT_W-1:0]         occupancy;
  logic                              skip_possible;

  modport source (output valid, status, entry_priority, entry_blocking, entry_type,
                  type_count, occupancy, skip_possible, input ready);
  modport sink   (input valid, status, entry_priority, entry_blocking, entry_type,
                  type_count, occupancy, skip_possible, output ready);
endinterface

/* rtl/sorted_priority_queue_with_skip_unit.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue_with_skip_unit: insert moves each entry above the new one up a slot,
// remove moves each entry above the gap down a slot, count reads every entry once
// one request at a time; every step goes through the entry ram, one write and one registered read per cycle
// async active-low reset empties the queue, clears cursor and extremes, spacing back to 10
// ----------------------------------------------------------------------------
module sorted_priority_queue_with_skip_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  spq_req_if.sink                         req_i,
  spq_rsp_if.source                       rsp_o,
  input  logic                            cfg_we_i,
  input  logic [spq_pkg::SPACING_W-1:0]   cfg_wdata_i
);

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  spq_pkg::state_e                 state_q, state_d;

  // latched request
  spq_pkg::kind_e                  kind_q, kind_d;
  spq_pkg::prio_t                  prio_q, prio_d;
  logic                            blk_q, blk_d;
  logic [spq_pkg::TYPE_W-1:0]      tag_q, tag_d;
  logic                            bottom_q, bottom_d;   // insert goes below everything

  // walking pointer for shifts and scans
  logic [spq_pkg::CNT_W-1:0]       ptr_q, ptr_d;

  // queue bookkeeping
  logic [spq_pkg::CNT_W-1:0]       count_q, count_d;
  logic [spq_pkg::IDX_W-1:0]       cursor_q, cursor_d;
  spq_pkg::prio_t                  low_q, low_d;
  spq_pkg::prio_t                  high_q, high_d;
  logic [spq_pkg::SPACING_W-1:0]   spacing_q;

  // result being built
  spq_pkg::status_e                res_status_q, res_status_d;
  spq_pkg::entry_t                 res_entry_q, res_entry_d;
  logic [spq_pkg::CNT_W-1:0]       tally_q, tally_d;

  // output register
  logic                            rsp_valid_q, rsp_valid_d;
  spq_pkg::status_e                rsp_status_q, rsp_status_d;
  spq_pkg::entry_t                 rsp_entry_q, rsp_entry_d;
  logic [spq_pkg::CNT_W-1:0]       rsp_tally_q, rsp_tally_d;
  logic [spq_pkg::CNT_W-1:0]       rsp_occ_q, rsp_occ_d;
  logic                            rsp_skip_q, rsp_skip_d;

  // entry ram, slot 0 is the lowest priority, slot count-1 the top
  spq_pkg::entry_t                 mem [spq_pkg::DEPTH];
  spq_pkg::entry_t                 rd_q;
  logic [spq_pkg::IDX_W-1:0]       mem_raddr;
  logic                            mem_we;
  logic [spq_pkg::IDX_W-1:0]       mem_waddr;
  spq_pkg::entry_t                 mem_wdata;

  // --------------------------------------------------------------------------
  // shared helpers
  // --------------------------------------------------------------------------
  logic                            req_fire;
  spq_pkg::kind_e                  req_kind;
  logic [spq_pkg::CNT_W-1:0]       ptr_inc, ptr_dec, count_dec, cursor_ext;
  logic [spq_pkg::CNT_W-1:0]       cur_clip, cur_idx, skip_idx;
  logic                            can_skip, queue_full, queue_empty, out_free;
  spq_pkg::prio_t                  top_ref, bot_ref, ins_prio;
  logic                            ins_bottom, shift_up, tag_hit, fin_skip;
  spq_pkg::entry_t                 new_entry;

  assign req_i.ready = (state_q == spq_pkg::S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign req_kind    = spq_pkg::kind_e'(req_i.kind);

  assign ptr_inc    = ptr_q + spq_pkg::CNT_W'(1);
  assign ptr_dec    = ptr_q - spq_pkg::CNT_W'(1);
  assign count_dec  = count_q - spq_pkg::CNT_W'(1);
  assign cursor_ext = spq_pkg::CNT_W'(cursor_q);

  assign queue_full  = (count_q == spq_pkg::CNT_W'(spq_pkg::DEPTH));
  assign queue_empty = (count_q == '0);

  // skip needs an entry below the cursor entry
  assign can_skip = (count_q > cursor_ext + spq_pkg::CNT_W'(1));
  assign skip_idx = count_dec - cursor_ext;

  // a stale cursor sticks at the bottom entry
  assign cur_clip = (cursor_ext > count_dec) ? count_dec : cursor_ext;
  assign cur_idx  = count_dec - cur_clip;

  // saturated references for insert at top and at bottom
  assign top_ref = spq_pkg::sat_prio(spq_pkg::SUM_W'(high_q)
                   + spq_pkg::SUM_W'(signed'({1'b0, spacing_q})));
  assign bot_ref = spq_pkg::sat_prio(spq_pkg::SUM_W'(low_q)
                   - spq_pkg::SUM_W'(spq_pkg::BOTTOM_STEP));

  always_comb begin
    case (req_kind)
      spq_pkg::K_INS_TOP: ins_prio = top_ref;
      spq_pkg::K_INS_BOT: ins_prio = bot_ref;
      default:            ins_prio = req_i.new_priority;
    endcase
  end

  assign ins_bottom = queue_empty || (ins_prio <= low_q);

  // the compares of the insert walk (shift_up) and the count scan (tag_hit)
  assign shift_up = bottom_q || (rd_q.prio > prio_q);
  assign tag_hit  = (rd_q.tag == tag_q);

  assign fin_skip  = can_skip && !rd_q.blk;
  assign out_free  = !rsp_valid_q || rsp_o.ready;
  assign new_entry = '{prio: prio_q, blk: blk_q, tag: tag_q};

  // --------------------------------------------------------------------------
  // sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      spq_pkg::S_IDLE: begin
        if (req_fire) begin
          case (req_kind)
            spq_pkg::K_INSERT, spq_pkg::K_INS_TOP, spq_pkg::K_INS_BOT: begin
              if (queue_full) begin
                state_d = spq_pkg::S_FIN_RD;
              end else if (queue_empty) begin
                state_d = spq_pkg::S_INS_PUT;
              end else begin
                state_d = spq_pkg::S_INS_RD;
              end
            end
            spq_pkg::K_REM_TOP, spq_pkg::K_REM_BOT,
            spq_pkg::K_GET_TOP, spq_pkg::K_GET_CUR: begin
              state_d = queue_empty ? spq_pkg::S_FIN_RD : spq_pkg::S_RD;
            end
            spq_pkg::K_SKIP: begin
              state_d = can_skip ? spq_pkg::S_SKIP : spq_pkg::S_FIN_RD;
            end
            spq_pkg::K_COUNT: begin
              state_d = queue_empty ? spq_pkg::S_FIN_RD : spq_pkg::S_CNT_RD;
            end
            default: begin
              state_d = spq_pkg::S_FIN_RD;
            end
          endcase
        end
      end
      spq_pkg::S_INS_RD: state_d = spq_pkg::S_INS_CMP;
      spq_pkg::S_INS_CMP: begin
        // keep walking down while entries sit above the new one
        if (shift_up && (ptr_q != spq_pkg::CNT_W'(1))) begin
          state_d = spq_pkg::S_INS_RD;
        end else begin
          state_d = spq_pkg::S_INS_PUT;
        end
      end
      spq_pkg::S_INS_PUT: state_d = spq_pkg::S_FIN_RD;
      spq_pkg::S_RD:      state_d = spq_pkg::S_RD_GET;
      spq_pkg::S_RD_GET: begin
        if (kind_q inside {spq_pkg::K_REM_TOP, spq_pkg::K_REM_BOT}) begin
          state_d = spq_pkg::S_RM_RD;
        end else begin
          state_d = spq_pkg::S_FIN_RD;
        end
      end
      spq_pkg::S_RM_RD: begin
        if (ptr_inc < count_q) begin
          state_d = spq_pkg::S_RM_WR;
        end else if (count_dec == '0) begin
          state_d = spq_pkg::S_FIN_RD;
        end else begin
          state_d = spq_pkg::S_REF_LO;
        end
      end
      spq_pkg::S_RM_WR:   state_d = spq_pkg::S_RM_RD;
      spq_pkg::S_REF_LO:  state_d = spq_pkg::S_REF_HI;
      spq_pkg::S_REF_HI:  state_d = spq_pkg::S_REF_END;
      spq_pkg::S_REF_END: state_d = spq_pkg::S_FIN_RD;
      spq_pkg::S_SKIP:    state_d = spq_pkg::S_FIN_RD;
      spq_pkg::S_CNT_RD:  state_d = spq_pkg::S_CNT_CMP;
      spq_pkg::S_CNT_CMP: begin
        state_d = (ptr_inc < count_q) ? spq_pkg::S_CNT_RD : spq_pkg::S_FIN_RD;
      end
      spq_pkg::S_FIN_RD:  state_d = spq_pkg::S_FIN;
      spq_pkg::S_FIN: begin
        // wait here while the previous response is still unclaimed
        if (out_free) begin
          state_d = spq_pkg::S_IDLE;
        end
      end
      default: state_d = spq_pkg::S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer: datapath and ram control
  // --------------------------------------------------------------------------
  always_comb begin
    kind_d       = kind_q;
    prio_d       = prio_q;
    blk_d        = blk_q;
    tag_d        = tag_q;
    bottom_d     = bottom_q;
    ptr_d        = ptr_q;
    count_d      = count_q;
    cursor_d     = cursor_q;
    low_d        = low_q;
    high_d       = high_q;
    res_status_d = res_status_q;
    res_entry_d  = res_entry_q;
    tally_d      = tally_q;

    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_entry_d  = rsp_entry_q;
    rsp_tally_d  = rsp_tally_q;
    rsp_occ_d    = rsp_occ_q;
    rsp_skip_d   = rsp_skip_q;

    mem_raddr = ptr_q[spq_pkg::IDX_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = ptr_q[spq_pkg::IDX_W-1:0];
    mem_wdata = rd_q;

    case (state_q)
      spq_pkg::S_IDLE: begin
        if (req_fire) begin
          kind_d       = req_kind;
          prio_d       = ins_prio;
          blk_d        = req_i.new_blocking;
          tag_d        = req_i.type_tag;
          bottom_d     = ins_bottom;
          ptr_d        = count_q;
          res_status_d = spq_pkg::ST_OK;
          res_entry_d  = '0;
          tally_d      = '0;
          case (req_kind)
            spq_pkg::K_INSERT, spq_pkg::K_INS_TOP, spq_pkg::K_INS_BOT: begin
              if (queue_full) begin
                res_status_d = spq_pkg::ST_FULL;
              end
            end
            spq_pkg::K_REM_TOP, spq_pkg::K_GET_CUR: begin
              if (queue_empty) begin
                res_status_d = spq_pkg::ST_EMPTY;
              end
              ptr_d = cur_idx;
            end
            spq_pkg::K_REM_BOT: begin
              if (queue_empty) begin
                res_status_d = spq_pkg::ST_EMPTY;
              end
              ptr_d = '0;
            end
            spq_pkg::K_GET_TOP: begin
              // cursor goes home even on an empty queue
              cursor_d = '0;
              if (queue_empty) begin
                res_status_d = spq_pkg::ST_EMPTY;
              end
              ptr_d = count_dec;
            end
            spq_pkg::K_SKIP: begin
              if (!can_skip) begin
                res_status_d = spq_pkg::ST_NOSKIP;
              end
              // fetch the cursor entry's blocking flag
              mem_raddr = skip_idx[spq_pkg::IDX_W-1:0];
            end
            spq_pkg::K_COUNT: begin
              ptr_d = '0;
            end
            spq_pkg::K_CLEAR: begin
              count_d = '0;
              low_d   = '0;
              high_d  = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // insert: walk from the top down, moving each higher entry up a slot
      spq_pkg::S_INS_RD: begin
        mem_raddr = ptr_dec[spq_pkg::IDX_W-1:0];
      end
      spq_pkg::S_INS_CMP: begin
        if (shift_up) begin
          mem_we = 1'b1;
          ptr_d  = ptr_dec;
        end
      end
      spq_pkg::S_INS_PUT: begin
        mem_we      = 1'b1;
        mem_wdata   = new_entry;
        count_d     = count_q + spq_pkg::CNT_W'(1);
        res_entry_d = new_entry;
        if (count_q == '0) begin
          low_d  = prio_q;
          high_d = prio_q;
        end else begin
          if (prio_q > high_q) begin
            high_d = prio_q;
          end
          if (prio_q < low_q) begin
            low_d = prio_q;
          end
        end
      end

      // read the selected entry
      spq_pkg::S_RD_GET: begin
        res_entry_d = rd_q;
      end

      // remove: close the gap by moving higher entries down a slot
      spq_pkg::S_RM_RD: begin
        mem_raddr = ptr_inc[spq_pkg::IDX_W-1:0];
        if (!(ptr_inc < count_q)) begin
          count_d = count_dec;
          if (count_dec == '0) begin
            low_d  = '0;
            high_d = '0;
          end
        end
      end
      spq_pkg::S_RM_WR: begin
        mem_we = 1'b1;
        ptr_d  = ptr_inc;
      end

      // refresh the extremes from bottom and top slots
      spq_pkg::S_REF_LO: begin
        mem_raddr = '0;
      end
      spq_pkg::S_REF_HI: begin
        low_d     = rd_q.prio;
        mem_raddr = count_dec[spq_pkg::IDX_W-1:0];
      end
      spq_pkg::S_REF_END: begin
        high_d = rd_q.prio;
      end

      spq_pkg::S_SKIP: begin
        if (rd_q.blk) begin
          res_status_d = spq_pkg::ST_NOSKIP;
        end else begin
          cursor_d = cursor_q + spq_pkg::IDX_W'(1);
        end
      end

      // count: read each entry in turn and tally those whose tag matches
      spq_pkg::S_CNT_CMP: begin
        if (tag_hit) begin
          tally_d = tally_q + spq_pkg::CNT_W'(1);
        end
        ptr_d = ptr_inc;
      end

      // look ahead whether one more skip would pass, then publish
      spq_pkg::S_FIN_RD: begin
        mem_raddr = skip_idx[spq_pkg::IDX_W-1:0];
      end
      spq_pkg::S_FIN: begin
        mem_raddr = skip_idx[spq_pkg::IDX_W-1:0];
        if (out_free) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = res_status_q;
          rsp_entry_d  = res_entry_q;
          rsp_tally_d  = tally_q;
          rsp_occ_d    = count_q;
          rsp_skip_d   = fin_skip;
        end
      end

      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spq_pkg::S_IDLE;
      count_q     <= '0;
      cursor_q    <= '0;
      low_q       <= '0;
      high_q      <= '0;
      spacing_q   <= spq_pkg::SPACING_W'(spq_pkg::SPACING_RST);
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cursor_q    <= cursor_d;
      low_q       <= low_d;
      high_q      <= high_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        spacing_q <= cfg_wdata_i;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    prio_q       <= prio_d;
    blk_q        <= blk_d;
    tag_q        <= tag_d;
    bottom_q     <= bottom_d;
    ptr_q        <= ptr_d;
    res_status_q <= res_status_d;
    res_entry_q  <= res_entry_d;
    tally_q      <= tally_d;
    rsp_status_q <= rsp_status_d;
    rsp_entry_q  <= rsp_entry_d;
    rsp_tally_q  <= rsp_tally_d;
    rsp_occ_q    <= rsp_occ_d;
    rsp_skip_q   <= rsp_skip_d;
  end

  // entry ram, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  // --------------------------------------------------------------------------
  // response port
  // --------------------------------------------------------------------------
  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = rsp_status_q;
  assign rsp_o.entry_priority = rsp_entry_q.prio;
  assign rsp_o.entry_blocking = rsp_entry_q.blk;
  assign rsp_o.entry_type     = rsp_entry_q.tag;
  assign rsp_o.type_count     = rsp_tally_q;
  assign rsp_o.occupancy      = rsp_occ_q;
  assign rsp_o.skip_possible  = rsp_skip_q;

endmodule

/* rtl/spq_checker.sv */
// ----------------------------------------------------------------------------
// spq_checker
// port level checks on the response channel of the queue
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spq_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              rsp_valid_i,
  input logic [1:0]                        rsp_status_i,
  input logic signed [spq_pkg::PRIO_W-1:0] rsp_priority_i,
  input logic                              rsp_blocking_i,
  input logic [spq_pkg::TYPE_W-1:0]        rsp_type_i,
  input logic [spq_pkg::CNT_W-1:0]         rsp_count_i,
  input logic [spq_pkg::CNT_W-1:0]         rsp_occupancy_i
);

  `ASSERT_ALWAYS(a_quiet_in_reset, clk_i, !rst_ni |-> !rsp_valid_i, "response during reset")

  // a refused request reports no entry
  `ASSERT_RST(a_err_no_entry, clk_i, rst_ni, (rsp_valid_i && rsp_status_i != spq_pkg::ST_OK) |-> (rsp_priority_i == '0 && !rsp_blocking_i && rsp_type_i == '0), "entry fields set on error")

  `ASSERT_RST(a_full_occ, clk_i, rst_ni, (rsp_valid_i && rsp_status_i == spq_pkg::ST_FULL) |-> (rsp_occupancy_i == spq_pkg::CNT_W'(spq_pkg::DEPTH)), "full status with free slots")

  `ASSERT_RST(a_empty_occ, clk_i, rst_ni, (rsp_valid_i && rsp_status_i == spq_pkg::ST_EMPTY) |-> (rsp_occupancy_i == '0), "empty status with entries")

  `ASSERT_RST(a_count_bound, clk_i, rst_ni, rsp_valid_i |-> (rsp_count_i <= rsp_occupancy_i), "type count above occupancy")

endmodule

bind sorted_priority_queue_with_skip_unit spq_checker u_spq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_status_i    (rsp_o.status),
  .rsp_priority_i  (rsp_o.entry_priority),
  .rsp_blocking_i  (rsp_o.entry_blocking),
  .rsp_type_i      (rsp_o.entry_type),
  .rsp_count_i     (rsp_o.type_count),
  .rsp_occupancy_i (rsp_o.occupancy)
);
